@@ hw/rtl/hsps_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the sps resolution parser
package hsps_pkg;

    typedef enum logic [29:0] {
        ST_HDR       = 30'h0000_0001,
        ST_PROFILE   = 30'h0000_0002,
        ST_CONSLEV   = 30'h0000_0004,
        ST_SPSID     = 30'h0000_0008,
        ST_CHROMA    = 30'h0000_0010,
        ST_SEPCOL    = 30'h0000_0020,
        ST_DEPTHL    = 30'h0000_0040,
        ST_DEPTHC    = 30'h0000_0080,
        ST_BYPASS    = 30'h0000_0100,
        ST_SMPRESENT = 30'h0000_0200,
        ST_LISTFLAG  = 30'h0000_0400,
        ST_DELTA     = 30'h0000_0800,
        ST_LOG2FN    = 30'h0000_1000,
        ST_POCTYPE   = 30'h0000_2000,
        ST_LOG2POC   = 30'h0000_4000,
        ST_DZERO     = 30'h0000_8000,
        ST_OFFNR     = 30'h0001_0000,
        ST_OFFTB     = 30'h0002_0000,
        ST_NUMCYC    = 30'h0004_0000,
        ST_CYCOFF    = 30'h0008_0000,
        ST_NUMREF    = 30'h0010_0000,
        ST_GAPS      = 30'h0020_0000,
        ST_WIDTH     = 30'h0040_0000,
        ST_HEIGHT    = 30'h0080_0000,
        ST_FRAMEONLY = 30'h0100_0000,
        ST_MBAFF     = 30'h0200_0000,
        ST_D8X8      = 30'h0400_0000,
        ST_CROPFLAG  = 30'h0800_0000,
        ST_CROP      = 30'h1000_0000,
        ST_DONE      = 30'h2000_0000
    } t_step;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_SHORT = 2'd1;
    localparam logic [1:0] STATUS_GOLOMB = 2'd2;

    localparam logic [7:0] SCALE_INIT = 8'd8;

    // controller to datapath
    typedef struct packed {
        logic  load;      // take a new word
        logic  clear;     // restart the parse
        logic  bit_en;    // consume one bit
        logic  load_out;  // capture the result
        logic  done;      // syntax finished
        t_step step;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic cur_bit;
        logic err;
        logic val_done;
        logic v_zero;
        logic v_one;
        logic v_three;
        logic hi_prof;
        logic cnt_wrap;
        logic delta_next;
        logic cyc_end;
        logic crop_end;
        logic list_end;
    } t_status;

    function automatic logic is_golomb(input t_step s);
        logic r;
        case (s)
            ST_SPSID, ST_CHROMA, ST_DEPTHL, ST_DEPTHC, ST_DELTA, ST_LOG2FN,
            ST_POCTYPE, ST_LOG2POC, ST_OFFNR, ST_OFFTB, ST_NUMCYC, ST_CYCOFF,
            ST_NUMREF, ST_WIDTH, ST_HEIGHT, ST_CROP: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_high_profile(input logic [7:0] p);
        logic r;
        case (p) inside
            8'd100, 8'd110, 8'd122, 8'd244, 8'd44, 8'd83, 8'd86, 8'd118,
            8'd128: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/hsps_if.sv @@
`timescale 1ns / 1ps
// valid/ready channel interfaces for input and result words
interface hsps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    modport source (output valid, data_byte, first_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface hsps_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] pic_width;
    logic [15:0] pic_height;
    logic [7:0]  profile_code;
    logic [1:0]  parse_status;
    modport source (output valid, pic_width, pic_height, profile_code, parse_status,
                    input ready);
    modport sink   (input valid, pic_width, pic_height, profile_code, parse_status,
                    output ready);
endinterface

@@ hw/rtl/hsps_datapath.sv @@
`timescale 1ns / 1ps
// bit datapath: exp-golomb decode, field registers and size arithmetic
module hsps_datapath #(
    parameter int MAX_PREFIX_ZEROS = 31
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hsps_pkg::t_cmd     i_cmd,
    input  logic [7:0]         i_data_byte,
    output hsps_pkg::t_status  o_status,
    output logic [15:0]        o_pic_width,
    output logic [15:0]        o_pic_height,
    output logic [7:0]         o_profile_code,
    output logic [1:0]         o_parse_status
);
    logic [7:0]  r_byte, n_byte;
    logic [5:0]  r_zc, n_zc;
    logic [31:0] r_acc, n_acc;
    logic        r_sfx, n_sfx;
    logic [31:0] r_fc, n_fc;
    logic [7:0]  r_prof, n_prof;
    logic        r_c444, n_c444;
    logic [3:0]  r_li, n_li;
    logic [7:0]  r_slast, n_slast;
    logic [15:0] r_wmb, n_wmb;
    logic [15:0] r_hu, n_hu;
    logic        r_fo, n_fo;
    logic [15:0] r_crop [4];
    logic [15:0] n_crop [4];
    logic        r_err, n_err;
    logic [15:0] r_ow, r_oh;
    logic [7:0]  r_op;
    logic [1:0]  r_os;

    logic        b, gstep, val, took;
    logic [5:0]  zc1;
    logic [31:0] acc1, v, fc_dec, fc_inc;
    logic [32:0] v_p1;
    logic [7:0]  delta, sn;
    logic [3:0]  li_inc;
    logic [15:0] w_c, h_c, h_base, crop_tb;

    assign b      = r_byte[7];
    assign gstep  = hsps_pkg::is_golomb(i_cmd.step);
    assign fc_dec = r_fc - 32'd1;
    assign fc_inc = r_fc + 32'd1;
    assign li_inc = r_li + 4'd1;

    always_comb begin
        // golomb prefix and suffix
        took = 1'b0;
        zc1  = r_zc;
        acc1 = r_acc;
        if (!r_sfx) begin
            if (b) begin
                took = 1'b1;
                acc1 = 32'd1;
            end
        end else begin
            took = 1'b1;
            acc1 = {r_acc[30:0], b};
            zc1  = r_zc - 6'd1;
        end
        val  = gstep && took && (zc1 == 6'd0);
        v    = acc1 - 32'd1;
        v_p1 = {1'b0, v} + 33'd1;
        delta = v[0] ? v_p1[8:1] : (8'd0 - v[8:1]);
        sn    = r_slast + delta;
    end

    always_comb begin
        o_status.cur_bit    = b;
        o_status.err        = r_err;
        o_status.val_done   = val;
        o_status.v_zero     = (v == 32'd0);
        o_status.v_one      = (v == 32'd1);
        o_status.v_three    = (v == 32'd3);
        o_status.hi_prof    = hsps_pkg::is_high_profile(r_prof);
        o_status.cnt_wrap   = (i_cmd.step == hsps_pkg::ST_CONSLEV) ? (fc_inc >= 32'd16)
                                                                 : (fc_inc >= 32'd8);
        o_status.delta_next = (fc_dec == 32'd0) || (sn == 8'd0);
        o_status.cyc_end    = (fc_dec == 32'd0);
        o_status.crop_end   = (fc_inc >= 32'd4);
        o_status.list_end   = (li_inc >= (r_c444 ? 4'd12 : 4'd8));
    end

    always_comb begin
        n_byte  = r_byte;
        n_zc    = r_zc;
        n_acc   = r_acc;
        n_sfx   = r_sfx;
        n_fc    = r_fc;
        n_prof  = r_prof;
        n_c444  = r_c444;
        n_li    = r_li;
        n_slast = r_slast;
        n_wmb   = r_wmb;
        n_hu    = r_hu;
        n_fo    = r_fo;
        n_crop  = r_crop;
        n_err   = r_err;
        if (i_cmd.load) begin
            n_byte = i_data_byte;
            if (i_cmd.clear) begin
                n_zc    = '0;
                n_acc   = '0;
                n_sfx   = 1'b0;
                n_fc    = '0;
                n_prof  = '0;
                n_c444  = 1'b0;
                n_li    = '0;
                n_slast = hsps_pkg::SCALE_INIT;
                n_wmb   = '0;
                n_hu    = '0;
                n_fo    = 1'b0;
                for (int k = 0; k < 4; k++) n_crop[k] = '0;
                n_err   = 1'b0;
            end
        end else if (i_cmd.bit_en) begin
            n_byte = {r_byte[6:0], 1'b0};
            if (gstep) begin
                if (!took) begin
                    n_zc = r_zc + 6'd1;
                    if (n_zc > 6'(MAX_PREFIX_ZEROS)) n_err = 1'b1;
                end else if (val) begin
                    n_zc  = '0;
                    n_acc = '0;
                    n_sfx = 1'b0;
                    case (i_cmd.step)
                        hsps_pkg::ST_CHROMA: n_c444 = (v == 32'd3);
                        hsps_pkg::ST_DELTA: begin
                            if (sn != 8'd0) n_slast = sn;
                            n_fc = fc_dec;
                            if ((fc_dec == 32'd0) || (sn == 8'd0)) n_li = li_inc;
                        end
                        hsps_pkg::ST_NUMCYC: n_fc = v;
                        hsps_pkg::ST_CYCOFF: n_fc = fc_dec;
                        hsps_pkg::ST_WIDTH:  n_wmb = v[15:0] + 16'd1;
                        hsps_pkg::ST_HEIGHT: n_hu = v[15:0] + 16'd1;
                        hsps_pkg::ST_CROP: begin
                            n_crop[r_fc[1:0]] = v[15:0];
                            n_fc = fc_inc;
                        end
                        default: ;
                    endcase
                end else begin
                    n_zc  = zc1;
                    n_acc = acc1;
                    n_sfx = 1'b1;
                end
            end else begin
                case (i_cmd.step)
                    hsps_pkg::ST_HDR: n_fc = (fc_inc >= 32'd8) ? 32'd0 : fc_inc;
                    hsps_pkg::ST_PROFILE: begin
                        n_prof = {r_prof[6:0], b};
                        n_fc = (fc_inc >= 32'd8) ? 32'd0 : fc_inc;
                    end
                    hsps_pkg::ST_CONSLEV: n_fc = (fc_inc >= 32'd16) ? 32'd0 : fc_inc;
                    hsps_pkg::ST_SMPRESENT: n_li = '0;
                    hsps_pkg::ST_LISTFLAG: begin
                        if (b) begin
                            n_fc    = (r_li < 4'd6) ? 32'd16 : 32'd64;
                            n_slast = hsps_pkg::SCALE_INIT;
                        end else begin
                            n_li = li_inc;
                        end
                    end
                    hsps_pkg::ST_FRAMEONLY: n_fo = b;
                    hsps_pkg::ST_CROPFLAG: if (b) n_fc = '0;
                    default: ;
                endcase
            end
        end
    end

    // result arithmetic, shifts and adds only
    always_comb begin
        w_c     = {r_wmb[11:0], 4'd0} - {r_crop[0][14:0], 1'b0} - {r_crop[1][14:0], 1'b0};
        h_base  = r_fo ? {r_hu[11:0], 4'd0} : {r_hu[10:0], 5'd0};
        crop_tb = r_crop[2] + r_crop[3];
        h_c     = h_base - (r_fo ? {crop_tb[14:0], 1'b0} : {crop_tb[13:0], 2'b0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte  <= '0;
            r_zc    <= '0;
            r_acc   <= '0;
            r_sfx   <= 1'b0;
            r_fc    <= '0;
            r_prof  <= '0;
            r_c444  <= 1'b0;
            r_li    <= '0;
            r_slast <= hsps_pkg::SCALE_INIT;
            r_wmb   <= '0;
            r_hu    <= '0;
            r_fo    <= 1'b0;
            for (int k = 0; k < 4; k++) r_crop[k] <= '0;
            r_err   <= 1'b0;
        end else begin
            r_byte  <= n_byte;
            r_zc    <= n_zc;
            r_acc   <= n_acc;
            r_sfx   <= n_sfx;
            r_fc    <= n_fc;
            r_prof  <= n_prof;
            r_c444  <= n_c444;
            r_li    <= n_li;
            r_slast <= n_slast;
            r_wmb   <= n_wmb;
            r_hu    <= n_hu;
            r_fo    <= n_fo;
            r_crop  <= n_crop;
            r_err   <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_ow <= w_c;
            r_oh <= h_c;
            r_op <= r_prof;
            r_os <= r_err ? hsps_pkg::STATUS_GOLOMB
                  : (i_cmd.done ? hsps_pkg::STATUS_OK : hsps_pkg::STATUS_SHORT);
        end
    end

    assign o_pic_width    = r_ow;
    assign o_pic_height   = r_oh;
    assign o_profile_code = r_op;
    assign o_parse_status = r_os;
endmodule

@@ hw/rtl/hsps_ctrl.sv @@
`timescale 1ns / 1ps
// controller: syntax state machine, bit sequencing and handshakes
module hsps_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_first,
    input  logic               i_last,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  hsps_pkg::t_status  i_status,
    output hsps_pkg::t_cmd     o_cmd
);
    hsps_pkg::t_step r_step, n_step;
    logic       r_busy, n_busy;
    logic       r_emit, n_emit;
    logic       r_last, n_last;
    logic [2:0] r_cnt, n_cnt;
    logic       r_ov, n_ov;
    logic       accept, bit_en, load_out;

    assign o_in_ready  = !r_busy;
    assign o_out_valid = r_ov;
    assign accept      = i_in_valid && !r_busy;
    assign bit_en      = r_busy && !r_emit && (r_step != hsps_pkg::ST_DONE) && !i_status.err;
    assign load_out    = r_emit && (!r_ov || i_out_ready);

    always_comb begin
        o_cmd.load     = accept;
        o_cmd.clear    = accept && i_first;
        o_cmd.bit_en   = bit_en;
        o_cmd.load_out = load_out;
        o_cmd.done     = (r_step == hsps_pkg::ST_DONE);
        o_cmd.step     = r_step;
    end

    // syntax walk
    always_comb begin
        n_step = r_step;
        if (accept && i_first) begin
            n_step = hsps_pkg::ST_HDR;
        end else if (bit_en) begin
            case (r_step)
                hsps_pkg::ST_HDR:
                    if (i_status.cnt_wrap) n_step = hsps_pkg::ST_PROFILE;
                hsps_pkg::ST_PROFILE:
                    if (i_status.cnt_wrap) n_step = hsps_pkg::ST_CONSLEV;
                hsps_pkg::ST_CONSLEV:
                    if (i_status.cnt_wrap) n_step = hsps_pkg::ST_SPSID;
                hsps_pkg::ST_SEPCOL:    n_step = hsps_pkg::ST_DEPTHL;
                hsps_pkg::ST_BYPASS:    n_step = hsps_pkg::ST_SMPRESENT;
                hsps_pkg::ST_SMPRESENT:
                    n_step = i_status.cur_bit ? hsps_pkg::ST_LISTFLAG : hsps_pkg::ST_LOG2FN;
                hsps_pkg::ST_LISTFLAG:
                    if (i_status.cur_bit) n_step = hsps_pkg::ST_DELTA;
                    else if (i_status.list_end) n_step = hsps_pkg::ST_LOG2FN;
                hsps_pkg::ST_DZERO:     n_step = hsps_pkg::ST_OFFNR;
                hsps_pkg::ST_GAPS:      n_step = hsps_pkg::ST_WIDTH;
                hsps_pkg::ST_FRAMEONLY:
                    n_step = i_status.cur_bit ? hsps_pkg::ST_D8X8 : hsps_pkg::ST_MBAFF;
                hsps_pkg::ST_MBAFF:     n_step = hsps_pkg::ST_D8X8;
                hsps_pkg::ST_D8X8:      n_step = hsps_pkg::ST_CROPFLAG;
                hsps_pkg::ST_CROPFLAG:
                    n_step = i_status.cur_bit ? hsps_pkg::ST_CROP : hsps_pkg::ST_DONE;
                default: begin
                    if (i_status.val_done) begin
                        case (r_step)
                            hsps_pkg::ST_SPSID: n_step = i_status.hi_prof
                                ? hsps_pkg::ST_CHROMA : hsps_pkg::ST_LOG2FN;
                            hsps_pkg::ST_CHROMA: n_step = i_status.v_three
                                ? hsps_pkg::ST_SEPCOL : hsps_pkg::ST_DEPTHL;
                            hsps_pkg::ST_DEPTHL: n_step = hsps_pkg::ST_DEPTHC;
                            hsps_pkg::ST_DEPTHC: n_step = hsps_pkg::ST_BYPASS;
                            hsps_pkg::ST_DELTA:
                                if (i_status.delta_next)
                                    n_step = i_status.list_end ? hsps_pkg::ST_LOG2FN
                                                               : hsps_pkg::ST_LISTFLAG;
                            hsps_pkg::ST_LOG2FN: n_step = hsps_pkg::ST_POCTYPE;
                            hsps_pkg::ST_POCTYPE:
                                if (i_status.v_zero) n_step = hsps_pkg::ST_LOG2POC;
                                else if (i_status.v_one) n_step = hsps_pkg::ST_DZERO;
                                else n_step = hsps_pkg::ST_NUMREF;
                            hsps_pkg::ST_LOG2POC: n_step = hsps_pkg::ST_NUMREF;
                            hsps_pkg::ST_OFFNR:   n_step = hsps_pkg::ST_OFFTB;
                            hsps_pkg::ST_OFFTB:   n_step = hsps_pkg::ST_NUMCYC;
                            hsps_pkg::ST_NUMCYC: n_step = i_status.v_zero
                                ? hsps_pkg::ST_NUMREF : hsps_pkg::ST_CYCOFF;
                            hsps_pkg::ST_CYCOFF:
                                if (i_status.cyc_end) n_step = hsps_pkg::ST_NUMREF;
                            hsps_pkg::ST_NUMREF:  n_step = hsps_pkg::ST_GAPS;
                            hsps_pkg::ST_WIDTH:   n_step = hsps_pkg::ST_HEIGHT;
                            hsps_pkg::ST_HEIGHT:  n_step = hsps_pkg::ST_FRAMEONLY;
                            hsps_pkg::ST_CROP:
                                if (i_status.crop_end) n_step = hsps_pkg::ST_DONE;
                            default: ;
                        endcase
                    end
                end
            endcase
        end
    end

    // bit sequencing and result slot
    always_comb begin
        n_busy = r_busy;
        n_emit = r_emit;
        n_last = r_last;
        n_cnt  = r_cnt;
        n_ov   = r_ov;
        if (r_ov && i_out_ready) n_ov = 1'b0;
        if (accept) begin
            n_busy = 1'b1;
            n_last = i_last;
            n_cnt  = '0;
        end else if (r_busy && !r_emit) begin
            n_cnt = r_cnt + 3'd1;
            if (r_cnt == 3'd7) begin
                if (r_last) n_emit = 1'b1;
                else n_busy = 1'b0;
            end
        end else if (load_out) begin
            n_ov   = 1'b1;
            n_emit = 1'b0;
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= hsps_pkg::ST_HDR;
            r_busy <= 1'b0;
            r_emit <= 1'b0;
            r_last <= 1'b0;
            r_cnt  <= '0;
            r_ov   <= 1'b0;
        end else begin
            r_step <= n_step;
            r_busy <= n_busy;
            r_emit <= n_emit;
            r_last <= n_last;
            r_cnt  <= n_cnt;
            r_ov   <= n_ov;
        end
    end
endmodule

@@ hw/rtl/h264_sps_resolution_parser.sv @@
`timescale 1ns / 1ps
// top level of the bit-serial sps resolution parser
//
//  channel  dir  payload                                             handshake
//  i_in     in   data_byte, first_byte, last_byte                    valid/ready
//  o_out    out  pic_width, pic_height, profile_code, parse_status   valid/ready
//
// each word is taken in, then shifted bit by bit through the
// golomb decoder and syntax state machine
// a word with last_byte then loads the result register, waiting while a
// previous result is still held there; ready stays low meanwhile
// reset restores the header state; first_byte restarts the parse
module h264_sps_resolution_parser #(
    parameter int MAX_PREFIX_ZEROS = 31
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hsps_in_if.sink    i_in,
    hsps_out_if.source o_out
);
    hsps_pkg::t_cmd    cmd;
    hsps_pkg::t_status status;

    hsps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_first     (i_in.first_byte),
        .i_last      (i_in.last_byte),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    hsps_datapath #(
        .MAX_PREFIX_ZEROS (MAX_PREFIX_ZEROS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_data_byte    (i_in.data_byte),
        .o_status       (status),
        .o_pic_width    (o_out.pic_width),
        .o_pic_height   (o_out.pic_height),
        .o_profile_code (o_out.profile_code),
        .o_parse_status (o_out.parse_status)
    );
endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// testbench for the sps resolution parser: random sps units, checked against a bit-serial model
module tb_top;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
    } t_word;

    typedef struct packed {
        logic [15:0] width;
        logic [15:0] height;
        logic [7:0]  profile;
        logic [1:0]  status;
    } t_res;

    localparam int MAXZ = 31;
    localparam int LIMIT = 2000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    hsps_in_if  in_ch();
    hsps_out_if out_ch();

    h264_sps_resolution_parser #(.MAX_PREFIX_ZEROS(MAXZ)) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    hsps_pkg::t_step m_step;
    int unsigned m_zeros, m_acc, m_cnt, m_list;
    bit          m_suffix, m_444, m_frame, m_done, m_err;
    logic [7:0]  m_prof, m_last, m_next;
    logic [15:0] m_w, m_h;
    logic [15:0] m_crop [4];

    t_word pending_words[$];
    t_res  expected_res[$];
    int    errors = 0;
    int    n_results = 0;
    int    n_units = 0;
    bit    stim_done = 0;

    // bit-level builder for sps units
    bit    bits[$];

    function automatic void add_bit(bit x);
        bits.insert(bits.size(), x);
    endfunction

    function automatic void queue_word(t_word w);
        pending_words.insert(pending_words.size(), w);
    endfunction

    function automatic void put_bits(int unsigned v, int n);
        for (int i = n - 1; i >= 0; i--) add_bit(v[i]);
    endfunction

    function automatic void put_ue(longint unsigned v);
        longint unsigned c;
        int n;
        c = v + 1;
        n = 0;
        while ((c >> (n + 1)) != 0) n++;
        for (int i = 0; i < n; i++) add_bit(1'b0);
        for (int i = n; i >= 0; i--) add_bit(c[i]);
    endfunction

    function automatic void model_reset();
        m_step = hsps_pkg::ST_HDR; m_zeros = 0; m_acc = 0; m_suffix = 0; m_cnt = 0;
        m_prof = 0; m_444 = 0; m_list = 0;
        m_last = hsps_pkg::SCALE_INIT; m_next = hsps_pkg::SCALE_INIT;
        m_w = 0; m_h = 0; m_frame = 0; m_done = 0; m_err = 0;
        for (int i = 0; i < 4; i++) m_crop[i] = 0;
    endfunction

    function automatic void advance_list();
        m_list = (m_list + 1) & 15;
        m_step = (m_list >= (m_444 ? 12 : 8)) ? hsps_pkg::ST_LOG2FN : hsps_pkg::ST_LISTFLAG;
    endfunction

    function automatic void take_value(int unsigned v);
        logic [7:0] d;
        case (m_step)
            hsps_pkg::ST_SPSID: m_step = hsps_pkg::is_high_profile(m_prof)
                ? hsps_pkg::ST_CHROMA : hsps_pkg::ST_LOG2FN;
            hsps_pkg::ST_CHROMA: begin
                m_444 = (v == 3);
                m_step = m_444 ? hsps_pkg::ST_SEPCOL : hsps_pkg::ST_DEPTHL;
            end
            hsps_pkg::ST_DEPTHL: m_step = hsps_pkg::ST_DEPTHC;
            hsps_pkg::ST_DEPTHC: m_step = hsps_pkg::ST_BYPASS;
            hsps_pkg::ST_DELTA: begin
                if (v[0]) d = 8'((33'(v) + 1) >> 1);
                else d = 8'(0 - (v >> 1));
                m_next = m_last + d;
                if (m_next != 0) m_last = m_next;
                m_cnt--;
                if (m_cnt == 0 || m_next == 0) advance_list();
            end
            hsps_pkg::ST_LOG2FN:  m_step = hsps_pkg::ST_POCTYPE;
            hsps_pkg::ST_POCTYPE: begin
                if (v == 0) m_step = hsps_pkg::ST_LOG2POC;
                else if (v == 1) m_step = hsps_pkg::ST_DZERO;
                else m_step = hsps_pkg::ST_NUMREF;
            end
            hsps_pkg::ST_LOG2POC: m_step = hsps_pkg::ST_NUMREF;
            hsps_pkg::ST_OFFNR:   m_step = hsps_pkg::ST_OFFTB;
            hsps_pkg::ST_OFFTB:   m_step = hsps_pkg::ST_NUMCYC;
            hsps_pkg::ST_NUMCYC: begin
                m_cnt = v;
                m_step = (v == 0) ? hsps_pkg::ST_NUMREF : hsps_pkg::ST_CYCOFF;
            end
            hsps_pkg::ST_CYCOFF: begin
                m_cnt--;
                if (m_cnt == 0) m_step = hsps_pkg::ST_NUMREF;
            end
            hsps_pkg::ST_NUMREF: m_step = hsps_pkg::ST_GAPS;
            hsps_pkg::ST_WIDTH: begin
                m_w = 16'(v + 1);
                m_step = hsps_pkg::ST_HEIGHT;
            end
            hsps_pkg::ST_HEIGHT: begin
                m_h = 16'(v + 1);
                m_step = hsps_pkg::ST_FRAMEONLY;
            end
            hsps_pkg::ST_CROP: begin
                m_crop[m_cnt & 3] = 16'(v);
                m_cnt++;
                if (m_cnt >= 4) begin
                    m_done = 1; m_step = hsps_pkg::ST_DONE;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void take_flag(bit b);
        case (m_step)
            hsps_pkg::ST_HDR: begin
                m_cnt++;
                if (m_cnt >= 8) begin m_cnt = 0; m_step = hsps_pkg::ST_PROFILE; end
            end
            hsps_pkg::ST_PROFILE: begin
                m_prof = {m_prof[6:0], b};
                m_cnt++;
                if (m_cnt >= 8) begin m_cnt = 0; m_step = hsps_pkg::ST_CONSLEV; end
            end
            hsps_pkg::ST_CONSLEV: begin
                m_cnt++;
                if (m_cnt >= 16) begin m_cnt = 0; m_step = hsps_pkg::ST_SPSID; end
            end
            hsps_pkg::ST_SEPCOL: m_step = hsps_pkg::ST_DEPTHL;
            hsps_pkg::ST_BYPASS: m_step = hsps_pkg::ST_SMPRESENT;
            hsps_pkg::ST_SMPRESENT: begin
                m_list = 0;
                m_step = b ? hsps_pkg::ST_LISTFLAG : hsps_pkg::ST_LOG2FN;
            end
            hsps_pkg::ST_LISTFLAG: begin
                if (b) begin
                    m_cnt = (m_list < 6) ? 16 : 64;
                    m_last = hsps_pkg::SCALE_INIT; m_next = hsps_pkg::SCALE_INIT;
                    m_step = hsps_pkg::ST_DELTA;
                end else advance_list();
            end
            hsps_pkg::ST_DZERO: m_step = hsps_pkg::ST_OFFNR;
            hsps_pkg::ST_GAPS:  m_step = hsps_pkg::ST_WIDTH;
            hsps_pkg::ST_FRAMEONLY: begin
                m_frame = b;
                m_step = b ? hsps_pkg::ST_D8X8 : hsps_pkg::ST_MBAFF;
            end
            hsps_pkg::ST_MBAFF: m_step = hsps_pkg::ST_D8X8;
            hsps_pkg::ST_D8X8:  m_step = hsps_pkg::ST_CROPFLAG;
            hsps_pkg::ST_CROPFLAG: begin
                if (b) begin m_cnt = 0; m_step = hsps_pkg::ST_CROP; end
                else begin m_done = 1; m_step = hsps_pkg::ST_DONE; end
            end
            default: ;
        endcase
    endfunction

    function automatic void parse_bit(bit b);
        int unsigned v;
        if (m_done || m_err) return;
        if (!hsps_pkg::is_golomb(m_step)) begin
            take_flag(b);
            return;
        end
        if (!m_suffix) begin
            if (!b) begin
                m_zeros++;
                if (m_zeros > MAXZ) m_err = 1;
                return;
            end
            m_acc = 1;
            m_suffix = 1;
        end else begin
            m_acc = (m_acc << 1) | b;
            m_zeros--;
        end
        if (m_zeros == 0) begin
            v = m_acc - 1;
            m_suffix = 0;
            m_acc = 0;
            take_value(v);
        end
    endfunction

    function automatic void predict_word(t_word wd);
        t_res r;
        if (wd.first) model_reset();
        for (int i = 7; i >= 0; i--) parse_bit(wd.data[i]);
        if (!wd.last) return;
        r.width = 16'(m_w * 16 - 2 * m_crop[0] - 2 * m_crop[1]);
        r.height = 16'((m_frame ? 16'd1 : 16'd2) * m_h * 16
                       - (m_frame ? 16'd2 : 16'd4) * (m_crop[2] + m_crop[3]));
        r.profile = m_prof;
        r.status = m_err ? hsps_pkg::STATUS_GOLOMB
                 : (m_done ? hsps_pkg::STATUS_OK : hsps_pkg::STATUS_SHORT);
        expected_res.insert(expected_res.size(), r);
    endfunction

    // pack bit list into words; keep_bits drops trailing bits to end the unit early
    function automatic void emit_unit(int keep_bits);
        int nb, nw;
        t_word wd;
        while (bits.size() % 8 != 0) add_bit(1'($urandom_range(0, 1)));
        nb = bits.size();
        if (keep_bits > 0 && keep_bits < nb) nb = keep_bits;
        nw = (nb + 7) / 8;
        for (int k = 0; k < nw; k++) begin
            for (int i = 0; i < 8; i++) wd.data[7 - i] = bits[k * 8 + i];
            wd.first = (k == 0);
            wd.last = (k == nw - 1);
            queue_word(wd);
        end
        bits.delete();
        n_units++;
    endfunction

    function automatic int unsigned rand_ue(int unsigned wide);
        case ($urandom_range(0, 9))
            0: return wide;
            1, 2: return $urandom_range(0, 255);
            default: return $urandom_range(0, 6);
        endcase
    endfunction

    // builds one well-formed sps with random content
    function automatic void build_sps(logic [7:0] prof, int poc, int lists, bit frame,
                                      bit crop, int unsigned wd, int unsigned ht);
        int ncyc, nd;
        int unsigned chroma;
        put_bits($urandom_range(0, 255), 8);
        put_bits(prof, 8);
        put_bits($urandom(), 16);
        put_ue(rand_ue(0));
        if (hsps_pkg::is_high_profile(prof)) begin
            chroma = $urandom_range(0, 3);
            put_ue(chroma);
            if (chroma == 3) put_bits($urandom_range(0, 1), 1);
            put_ue($urandom_range(0, 6));
            put_ue($urandom_range(0, 6));
            put_bits($urandom_range(0, 1), 1);
            put_bits(lists != 0, 1);
            if (lists != 0) begin
                for (int l = 0; l < ((chroma == 3) ? 12 : 8); l++) begin
                    put_bits(lists == 2 || $urandom_range(0, 1), 1);
                    if (lists == 2 || bits[bits.size() - 1]) begin
                        // some lists end early on a zero next scale
                        nd = (l < 6) ? 16 : 64;
                        if ($urandom_range(0, 2) == 0) begin
                            put_ue(16);  // delta -8 from 8 hits zero
                        end else begin
                            for (int j = 0; j < nd; j++)
                                put_ue(($urandom_range(0, 3) == 0) ? $urandom_range(0, 600)
                                                                   : $urandom_range(1, 4));
                        end
                    end
                end
            end
        end
        put_ue(rand_ue(12));
        put_ue(poc);
        if (poc == 0) put_ue(rand_ue(12));
        else if (poc == 1) begin
            put_bits($urandom_range(0, 1), 1);
            put_ue(rand_ue(100000));
            put_ue(rand_ue(100000));
            ncyc = $urandom_range(0, 5);
            put_ue(ncyc);
            for (int j = 0; j < ncyc; j++) put_ue(rand_ue(70000));
        end
        put_ue(rand_ue(16));
        put_bits($urandom_range(0, 1), 1);
        put_ue(wd);
        put_ue(ht);
        put_bits(frame, 1);
        if (!frame) put_bits($urandom_range(0, 1), 1);
        put_bits($urandom_range(0, 1), 1);
        put_bits(crop, 1);
        if (crop)
            for (int j = 0; j < 4; j++) put_ue(rand_ue(70000));
        // trailing bits, parse must ignore them
        for (int j = $urandom_range(0, 12); j > 0; j--) add_bit(1'($urandom_range(0, 1)));
    endfunction

    function automatic logic [7:0] rand_profile();
        logic [7:0] hp[9] = '{8'd100, 8'd110, 8'd122, 8'd244, 8'd44, 8'd83, 8'd86,
                               8'd118, 8'd128};
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(0, 255));
            1: return 8'd66;
            default: return hp[$urandom_range(0, 8)];
        endcase
    endfunction

    initial begin
        int sel, nb;
        t_word wd;
        model_reset();
        // directed part
        build_sps(8'd66, 0, 0, 1, 0, 0, 0);              emit_unit(0);
        build_sps(8'd100, 1, 2, 0, 1, 32'hFFFF, 32'hFFFF); emit_unit(0);
        build_sps(8'd244, 2, 1, 1, 1, 119, 67);          emit_unit(0);
        build_sps(8'd77, 1, 0, 0, 1, 1000, 70000);       emit_unit(40);
        // prefix too long: 40 zeros in the sps id
        put_bits(8'h67, 8); put_bits(8'd66, 8); put_bits(16'h0, 16);
        for (int j = 0; j < 40; j++) add_bit(1'b0);
        emit_unit(0);
        // exactly the maximum prefix, long value
        put_bits(8'h67, 8); put_bits(8'd66, 8); put_bits(16'hFFFF, 16);
        put_ue(64'hFFFF_FFFE);
        emit_unit(0);
        wd = t_word'{8'hFF, 1'b1, 1'b1}; queue_word(wd);
        wd = t_word'{8'h00, 1'b1, 1'b1}; queue_word(wd);
        // continuation without first_byte
        wd = t_word'{8'hA5, 1'b0, 1'b1}; queue_word(wd);
        // random part
        while (pending_words.size() < 1550) begin
            sel = $urandom_range(0, 9);
            if (sel < 7) begin
                build_sps(rand_profile(), $urandom_range(0, 3), $urandom_range(0, 2),
                          $urandom_range(0, 1), $urandom_range(0, 1),
                          rand_ue(32'hFFFF), rand_ue(32'hFFFF));
                emit_unit((sel == 6) ? $urandom_range(1, 60) : 0);
            end else begin
                nb = $urandom_range(1, 12);
                for (int k = 0; k < nb; k++) begin
                    wd.data = 8'($urandom_range(0, 255));
                    wd.first = (k == 0) ? (sel != 9) : ($urandom_range(0, 9) == 0);
                    wd.last = (k == nb - 1) || ($urandom_range(0, 7) == 0);
                    queue_word(wd);
                end
            end
        end
        stim_done = 1;
    end

    task automatic wd_drive(t_word w);
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= w.data;
        in_ch.first_byte <= w.first;
        in_ch.last_byte <= w.last;
    endtask

    // driver: bursts and gaps
    int burst_left = 0, gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.data_byte <= '0;
            in_ch.first_byte <= 1'b0;
            in_ch.last_byte <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid)
                predict_word(t_word'{in_ch.data_byte, in_ch.first_byte, in_ch.last_byte});
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_ch.valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
                wd_drive(pending_words.pop_front());
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
                end else burst_left <= burst_left - 1;
            end else in_ch.valid <= 1'b0;
        end
    end

    // monitor with its own stall pattern
    int stall_phase = 0;
    always @(posedge i_clk) begin
        t_res e;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                n_results++;
                if (expected_res.size() == 0) begin
                    $error("result with nothing expected");
                    errors++;
                end else begin
                    e = expected_res.pop_front();
                    if (out_ch.pic_width !== e.width) begin
                        $error("pic_width exp %0d got %0d", e.width, out_ch.pic_width);
                        errors++;
                    end
                    if (out_ch.pic_height !== e.height) begin
                        $error("pic_height exp %0d got %0d", e.height, out_ch.pic_height);
                        errors++;
                    end
                    if (out_ch.profile_code !== e.profile) begin
                        $error("profile_code exp %0d got %0d", e.profile,
                               out_ch.profile_code);
                        errors++;
                    end
                    if (out_ch.parse_status !== e.status) begin
                        $error("parse_status exp %0d got %0d", e.status,
                               out_ch.parse_status);
                        errors++;
                    end
                end
            end
            stall_phase <= (stall_phase + 1) % 400;
            if (stall_phase < 150) out_ch.ready <= 1'b1;
            else if (stall_phase < 300) out_ch.ready <= ($urandom_range(0, 2) != 0);
            else out_ch.ready <= ($urandom_range(0, 7) == 0);
        end
    end

    int cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout with %0d results outstanding", expected_res.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done);
        @(posedge i_clk);
        while (pending_words.size() != 0 || in_ch.valid || expected_res.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("ran %0d sps units and noise bursts, %0d results checked",
                 n_units, n_results);
        if (errors == 0 && expected_res.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
